### rtl/rmst_pkg.sv
package rmst_pkg;

	// Tree geometry: LEAVES leaves, one level per cell, root at level 0.
	localparam int LEAVES = 1024;
	localparam int LW     = $clog2(LEAVES);
	localparam int LEVELS = LW + 1;
	// Node indices run up to 2*LEAVES, so they need two bits above a leaf offset.
	localparam int NW     = LW + 2;

	localparam logic signed [31:0] IDENT = 32'sd1000000000;

	typedef enum logic {
		FN_WRITE = 1'b0,
		FN_QUERY = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BUSY
	} state_t;

	// Token handed from one level to the next.
	// A write uses lo as the node index and lft as the value to store.
	typedef struct packed {
		logic              vld;
		func_t             op;
		logic [NW-1:0]     lo;
		logic [NW-1:0]     hi;
		logic signed [31:0] lft;
		logic signed [31:0] rgt;
	} tok_t;

	// Memory request from a cell to its level store.
	typedef struct packed {
		logic              we;
		logic [LW-1:0]     waddr;
		logic signed [31:0] wdata;
		logic [LW-1:0]     raddr0;
		logic [LW-1:0]     raddr1;
	} mem_req_t;

	function automatic logic signed [31:0] min2(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return (b < a) ? b : a;
	endfunction

endpackage

### rtl/rmst_in_if.sv
interface rmst_in_if import rmst_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               func;
	logic [LW-1:0]      leaf_index;
	logic signed [31:0] leaf_value;
	logic [LW:0]        range_lo;
	logic [LW:0]        range_hi;

	modport source (output valid, func, leaf_index, leaf_value, range_lo, range_hi,
		input ready);
	modport sink (input valid, func, leaf_index, leaf_value, range_lo, range_hi,
		output ready);
endinterface

### rtl/rmst_out_if.sv
interface rmst_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] min_value;

	modport source (output valid, min_value, input ready);
	modport sink (input valid, min_value, output ready);
endinterface

### rtl/rmst_ram.sv
module rmst_ram #(
	parameter int AW = 1
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic signed [31:0] wdata,
	input  logic [AW-1:0]      raddr0,
	input  logic [AW-1:0]      raddr1,
	output logic signed [31:0] rdata0,
	output logic signed [31:0] rdata1
);
	localparam int DEPTH = 2 ** AW;

	logic signed [31:0] mem [DEPTH];

	// One write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end
endmodule

### rtl/rmst_cell.sv
module rmst_cell import rmst_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  tok_t               tok_i,
	output tok_t               tok_o,
	output mem_req_t           req,
	input  logic signed [31:0] rd0,
	input  logic signed [31:0] rd1
);
	tok_t tok_s1;
	tok_t tok_s2;

	// Two stages: issue memory access, then combine the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
		end else begin
			tok_s1 <= tok_i;
			tok_s2 <= tok_s1;
		end
	end

	// A write stores its node and fetches the sibling; a query fetches both edges.
	always_comb begin
		logic [NW-1:0] him1;
		him1       = tok_s1.hi - NW'(1);
		req.we     = tok_s1.vld && (tok_s1.op == FN_WRITE);
		req.waddr  = tok_s1.lo[LW-1:0];
		req.wdata  = tok_s1.lft;
		req.raddr0 = (tok_s1.op == FN_WRITE) ? (tok_s1.lo[LW-1:0] ^ LW'(1))
			: tok_s1.lo[LW-1:0];
		req.raddr1 = him1[LW-1:0];
	end

	// Step of the bottom-up walk, then move to the parent level.
	always_comb begin
		logic [NW-1:0]      l;
		logic [NW-1:0]      h;
		logic signed [31:0] lf;
		logic signed [31:0] rg;
		l  = tok_s2.lo;
		h  = tok_s2.hi;
		lf = tok_s2.lft;
		rg = tok_s2.rgt;
		if (tok_s2.op == FN_WRITE) begin
			lf = min2(tok_s2.lft, rd0);
		end else if (l < h) begin
			if (l[0]) begin
				lf = min2(lf, rd0);
				l  = l + NW'(1);
			end
			if (h[0]) begin
				h  = h - NW'(1);
				rg = min2(rd1, rg);
			end
		end
		tok_o.vld = tok_s2.vld;
		tok_o.op  = tok_s2.op;
		tok_o.lo  = l >> 1;
		tok_o.hi  = h >> 1;
		tok_o.lft = lf;
		tok_o.rgt = rg;
	end
endmodule

### rtl/range_min_segment_tree_top.sv
// Range-minimum segment tree over LEAVES signed 32-bit leaves.
// Requests arrive on in_ch (valid/ready). A write request (func = 0) stores
// leaf_value at leaf_index and updates every ancestor; it gives no result.
// A query request (func = 1) returns on out_ch the minimum over the leaves
// [range_lo, range_hi), with range ends clamped to LEAVES; an empty range
// returns 1000000000.
// The tree is a row of one cell per level, leaf level first, each with its own
// node store. A request walks up the row through the registers of each cell,
// and a query result then passes the output register before it is valid on
// out_ch. One request is in flight at a time: a new request is accepted only
// once the last one has left the root cell.
// After reset every store is swept to 1000000000, one entry per cycle;
// in_ch ready stays low meanwhile.
// A query result is held in an output register. If the receiver stalls, a
// further request can still be accepted and run; its result is parked in a
// holding register, and in_ch ready stays low until that result moves on.
module range_min_segment_tree_top import rmst_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	rmst_in_if.sink  in_ch,
	rmst_out_if.source out_ch
);
	state_t             st_q, st_d;
	logic [LW-1:0]      clr_cnt_q;
	logic               clearing;
	logic               accept;
	logic               root_q;
	logic signed [31:0] res;
	logic               out_v_q;
	logic signed [31:0] out_q;
	logic               pend_v_q;
	logic signed [31:0] pend_q;
	logic [LW:0]        lo_c;
	logic [LW:0]        hi_c;
	tok_t               chain [LEVELS+1];

	assign clearing   = (st_q == ST_CLEAR);
	assign in_ch.ready = (st_q == ST_IDLE) && !pend_v_q;
	assign accept     = in_ch.valid && in_ch.ready;

	// State register and sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + LW'(1);
			end
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_CLEAR: if (clr_cnt_q == LW'(LEAVES - 1)) st_d = ST_IDLE;
			ST_IDLE:  if (accept) st_d = ST_BUSY;
			ST_BUSY:  if (chain[LEVELS].vld) st_d = ST_IDLE;
			default:  st_d = ST_CLEAR;
		endcase
	end

	// Clamp the range ends and form the token for the leaf level.
	always_comb begin
		lo_c = (in_ch.range_lo > (LW+1)'(LEAVES)) ? (LW+1)'(LEAVES) : in_ch.range_lo;
		hi_c = (in_ch.range_hi > (LW+1)'(LEAVES)) ? (LW+1)'(LEAVES) : in_ch.range_hi;
		chain[0].vld = accept;
		chain[0].op  = func_t'(in_ch.func);
		chain[0].hi  = NW'(LEAVES) + NW'(hi_c);
		chain[0].rgt = IDENT;
		if (func_t'(in_ch.func) == FN_WRITE) begin
			chain[0].lo  = NW'(LEAVES) + NW'(in_ch.leaf_index);
			chain[0].lft = in_ch.leaf_value;
		end else begin
			chain[0].lo  = NW'(LEAVES) + NW'(lo_c);
			chain[0].lft = IDENT;
		end
	end

	// One cell and one node store per tree level.
	for (genvar i = 0; i < LEVELS; i++) begin : g_lvl
		localparam int LV = LW - i;
		localparam int AW = (LV > 0) ? LV : 1;
		mem_req_t           req;
		logic signed [31:0] rd0;
		logic signed [31:0] rd1;

		rmst_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_i  (chain[i]),
			.tok_o  (chain[i+1]),
			.req    (req),
			.rd0    (rd0),
			.rd1    (rd1)
		);

		rmst_ram #(.AW(AW)) u_ram (
			.clk    (clk),
			.we     (clearing || req.we),
			.waddr  (clearing ? clr_cnt_q[AW-1:0] : req.waddr[AW-1:0]),
			.wdata  (clearing ? IDENT : req.wdata),
			.raddr0 (req.raddr0[AW-1:0]),
			.raddr1 (req.raddr1[AW-1:0]),
			.rdata0 (rd0),
			.rdata1 (rd1)
		);
	end

	assign root_q = chain[LEVELS].vld && (chain[LEVELS].op == FN_QUERY);
	assign res    = min2(chain[LEVELS].lft, chain[LEVELS].rgt);

	// Output register with a holding register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (out_v_q && out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			if (pend_v_q && (!out_v_q || out_ch.ready)) begin
				out_v_q  <= 1'b1;
				pend_v_q <= 1'b0;
			end else if (root_q) begin
				if (!out_v_q || out_ch.ready) begin
					out_v_q <= 1'b1;
				end else begin
					pend_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_v_q && (!out_v_q || out_ch.ready)) begin
			out_q <= pend_q;
		end else if (root_q) begin
			if (!out_v_q || out_ch.ready) begin
				out_q <= res;
			end else begin
				pend_q <= res;
			end
		end
	end

	assign out_ch.valid     = out_v_q;
	assign out_ch.min_value = out_q;

	// An accepted request keeps the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (st_q == ST_BUSY))
		else $error("accepted request did not mark the tree busy");

	// A request reaches the root only while one is in flight.
	a_root_busy: assert property (@(posedge clk) disable iff (!arst_n)
		chain[LEVELS].vld |-> (st_q == ST_BUSY))
		else $error("token reached the root with no request in flight");

	// A parked result exists only behind a full output register.
	a_pend_full: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> out_v_q)
		else $error("holding register used while output register empty");

	// No request enters during the clearing sweep.
	a_clear_noacc: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !accept)
		else $error("request accepted during clearing sweep");
endmodule

### bench/tb_range_min_segment_tree_top.sv
module tb_range_min_segment_tree_top;
	import rmst_pkg::*;

	logic clk;
	logic arst_n;

	rmst_in_if  req_ch ();
	rmst_out_if res_ch ();

	range_min_segment_tree_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req_ch.sink),
		.out_ch (res_ch.source)
	);

	// Shadow copy of the tree contents, kept only at the leaves.
	logic signed [31:0] leaf_shadow [LEAVES];
	logic signed [31:0] expected_mins [$];

	int mismatches;
	int queries_sent;
	int writes_sent;
	int results_seen;
	int stall_pct;
	int hold_cycles;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Minimum over the clamped half-open leaf range, computed directly.
	function automatic logic signed [31:0] leaf_range_min(input int lo, input int hi);
		logic signed [31:0] m;
		m = IDENT;
		if (hi > LEAVES) hi = LEAVES;
		if (lo > LEAVES) lo = LEAVES;
		for (int i = lo; i < hi; i++)
			if (leaf_shadow[i] < m) m = leaf_shadow[i];
		return m;
	endfunction

	// Offers one request, waits for its acceptance, and updates the prediction.
	// Valid stays high after acceptance; an idle cycle or a drain lowers it.
	task automatic send_request(input func_t fn, input int idx, input logic signed [31:0] val,
			input int lo, input int hi);
		while (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.func       <= fn;
		req_ch.leaf_index <= idx[LW-1:0];
		req_ch.leaf_value <= val;
		req_ch.range_lo   <= lo[LW:0];
		req_ch.range_hi   <= hi[LW:0];
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (fn == FN_WRITE) begin
			leaf_shadow[idx] = val;
			writes_sent++;
		end else begin
			expected_mins = {expected_mins, leaf_range_min(lo, hi)};
			queries_sent++;
		end
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (expected_mins.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(5))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return IDENT + $urandom_range(3) - 1;
			3: return $signed($urandom_range(2000)) - 1000;
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic test_directed();
		send_request(FN_QUERY, 0, 0, 0, LEAVES);
		send_request(FN_QUERY, 0, 0, 5, 6);
		send_request(FN_WRITE, 0, 32'sh8000_0000, 0, 0);
		send_request(FN_WRITE, LEAVES - 1, 32'sh7fff_ffff, 0, 0);
		send_request(FN_WRITE, 512, -7, 0, 0);
		send_request(FN_WRITE, 511, IDENT + 5, 0, 0);
		send_request(FN_WRITE, 341, 32'sh5555_5555, 0, 0);
		send_request(FN_WRITE, 682, 32'sh2aaa_aaaa, 0, 0);
		send_request(FN_QUERY, 0, 0, 0, 1);
		send_request(FN_QUERY, 0, 0, LEAVES - 1, LEAVES);
		send_request(FN_QUERY, 0, 0, 1, LEAVES);
		send_request(FN_QUERY, 0, 0, 1, 2047);
		send_request(FN_QUERY, 0, 0, 511, 512);
		send_request(FN_QUERY, 0, 0, 600, 2047);
		send_request(FN_QUERY, 0, 0, 2047, 2047);
		send_request(FN_QUERY, 0, 0, 1500, 3);
		send_request(FN_QUERY, 0, 0, 700, 300);
		send_request(FN_QUERY, 0, 0, 40, 40);
		send_request(FN_QUERY, 0, 0, 0, 0);
		send_request(FN_QUERY, 0, 0, 0, LEAVES);
		drain_results();
	endtask

	// Mostly writes and queries over random ranges, with out-of-table ends.
	task automatic test_random(input int count);
		int lo;
		int hi;
		for (int n = 0; n < count; n++) begin
			lo = $urandom_range(LEAVES - 1);
			hi = lo + $urandom_range(64);
			case ($urandom_range(9))
				0: begin lo = $urandom_range(2047); hi = $urandom_range(2047); end
				1: hi = LEAVES + $urandom_range(1023);
				2: hi = lo + 1;
				default: ;
			endcase
			if ($urandom_range(1))
				send_request(FN_WRITE, $urandom_range(LEAVES - 1), rand_value(),
					$urandom_range(2047), $urandom_range(2047));
			else
				send_request(FN_QUERY, $urandom_range(LEAVES - 1), rand_value(), lo, hi);
		end
	endtask

	// Receiver holds off for a long stretch while requests keep coming.
	task automatic test_backpressure();
		hold_cycles = 300;
		test_random(20);
		drain_results();
	endtask

	// Result checker.
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready) begin
			results_seen++;
			if (expected_mins.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result min_value=%0d", res_ch.min_value);
			end else begin
				if (res_ch.min_value !== expected_mins[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("min_value mismatch: expected %0d, got %0d",
							expected_mins[0], res_ch.min_value);
				end
				void'(expected_mins.pop_front());
			end
		end
	end

	// Receiver-side ready: a counted long hold when asked, random idling otherwise.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			res_ch.ready <= 1'b0;
		end else
			res_ch.ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FN_WRITE;
		req_ch.leaf_index = '0;
		req_ch.leaf_value = '0;
		req_ch.range_lo = '0;
		req_ch.range_hi = '0;
		res_ch.ready = 1'b0;
		mismatches = 0;
		queries_sent = 0;
		writes_sent = 0;
		results_seen = 0;
		stall_pct = 16;
		hold_cycles = 0;
		foreach (leaf_shadow[i]) leaf_shadow[i] = IDENT;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure();
		test_random(500);
		// Sender pauses until every outstanding result has returned.
		drain_results();
		stall_pct = 0;
		test_random(200);
		stall_pct = 16;
		test_random(460);
		drain_results();
		$display("Covered %0d leaf writes and %0d range queries, %0d results checked.",
			writes_sent, queries_sent, results_seen);
		if (mismatches == 0 && expected_mins.size() == 0)
			$display("tb_range_min_segment_tree_top: PASS");
		else
			$display("tb_range_min_segment_tree_top: FAIL");
		$finish;
	end

	// Run limit well above the slowest legal run.
	initial begin
		#2000000;
		$display("tb_range_min_segment_tree_top: FAIL");
		$finish;
	end

endmodule
